### rtl/dsis_pkg.sv
// Package for the deque store: request kinds, result status codes and the
// cell control codes shared by the cell row and the top level.
// No dependencies.
package dsis_pkg;

  localparam logic [1:0] K_PUSH_FRONT = 2'd0;
  localparam logic [1:0] K_PUSH_BACK  = 2'd1;
  localparam logic [1:0] K_READ       = 2'd2;
  localparam logic [1:0] K_FIND       = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_MISS  = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  typedef logic [1:0] cell_mode_t;

  localparam cell_mode_t CM_HOLD  = 2'd0;
  localparam cell_mode_t CM_SHIFT = 2'd1;
  localparam cell_mode_t CM_LOAD  = 2'd2;
  localparam cell_mode_t CM_ROT   = 2'd3;

endpackage

### rtl/dsis_cell.sv
// One storage cell of the deque row. Each cell holds one entry, takes data
// from neighbors or loads wr_data under a shared mode. Depends on dsis_pkg.
module dsis_cell import dsis_pkg::*; #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  cell_mode_t            mode,
  input  logic                  sel,
  input  logic [DATA_WIDTH-1:0] wr_data,
  input  logic [DATA_WIDTH-1:0] left_data,
  input  logic [DATA_WIDTH-1:0] right_data,
  output logic [DATA_WIDTH-1:0] data_out
);

  logic [DATA_WIDTH-1:0] data_r;
  logic [DATA_WIDTH-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    unique case (mode)
      CM_SHIFT: data_nxt = left_data;
      CM_LOAD: begin
        if (sel) begin
          data_nxt = wr_data;
        end
      end
      CM_ROT:  data_nxt = right_data;
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_out = data_r;

endmodule

### rtl/deque_store_with_index_and_search_top.sv
// Top level of the deque store: request sequencer, result register and the
// row of dsis_cell storage cells. Depends on dsis_pkg and dsis_cell.
//
//   Channel | Direction | Handshake           | Payload
//   in_     | input     | in_valid, in_stall  | in_kind, in_item_value, in_position
//   out_    | output    | out_valid, out_stall| out_status, out_read_value
//
// A push, or any request answered without a scan, has its result registered
// in the cycle after acceptance. A read by position or a find that reaches the
// scan is answered after one full rotation of the cell row past the front cell.
// Reset clears the count and control state; cell contents are not reset.
// The input stalls during a scan and while a result waits on out_stall.
module deque_store_with_index_and_search_top import dsis_pkg::*; #(
  parameter int DEPTH      = 256,
  parameter int DATA_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_kind,
  input  logic signed [31:0] in_item_value,
  input  logic [9:0]         in_position,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic signed [31:0] out_read_value
);

  localparam int CW  = $clog2(DEPTH + 1);
  localparam int IW  = $clog2(DEPTH);
  localparam int MW  = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
  localparam int PCW = (CW > 10) ? CW : 10;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic                  state_r, state_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [IW-1:0]         cnt_r, cnt_nxt;
  logic [1:0]            kind_r, kind_nxt;
  logic [9:0]            pos_r, pos_nxt;
  logic [DATA_WIDTH-1:0] key_r, key_nxt;
  logic                  found_r, found_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [1:0]            out_status_r, out_status_nxt;
  logic [31:0]           out_value_r, out_value_nxt;

  logic                  in_acc;
  logic                  out_acc;
  logic                  full;
  logic                  pos_ok;
  logic                  scan_live;
  logic [DATA_WIDTH-1:0] wr_data;
  logic [31:0]           head32;
  cell_mode_t            cell_mode;
  logic [DEPTH-1:0]      sel;
  logic [DATA_WIDTH-1:0] chain [DEPTH];

  assign in_stall  = (state_r == S_SCAN) || (out_valid_r && out_stall);
  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid_r && !out_stall;
  assign full      = (count_r == CW'(DEPTH));
  assign pos_ok    = (PCW'(in_position) < PCW'(count_r));
  assign scan_live = (CW'(cnt_r) < count_r);

  always_comb begin
    wr_data         = '0;
    wr_data[MW-1:0] = in_item_value[MW-1:0];
    head32          = '0;
    head32[MW-1:0]  = chain[0][MW-1:0];
  end

  always_comb begin
    cell_mode = CM_HOLD;
    if (state_r == S_SCAN) begin
      cell_mode = CM_ROT;
    end else if (in_acc && !full) begin
      if (in_kind == K_PUSH_FRONT) begin
        cell_mode = CM_SHIFT;
      end else if (in_kind == K_PUSH_BACK) begin
        cell_mode = CM_LOAD;
      end
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign sel[i] = (count_r == CW'(i));
    dsis_cell #(
      .DATA_WIDTH(DATA_WIDTH)
    ) u_cell (
      .clk       (clk),
      .mode      (cell_mode),
      .sel       (sel[i]),
      .wr_data   (wr_data),
      .left_data ((i == 0) ? wr_data : chain[(i + DEPTH - 1) % DEPTH]),
      .right_data(chain[(i + 1) % DEPTH]),
      .data_out  (chain[i])
    );
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    cnt_nxt        = cnt_r;
    kind_nxt       = kind_r;
    pos_nxt        = pos_r;
    key_nxt        = key_r;
    found_nxt      = found_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    if (out_acc) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          kind_nxt      = in_kind;
          pos_nxt       = in_position;
          key_nxt       = wr_data;
          found_nxt     = 1'b0;
          cnt_nxt       = '0;
          out_value_nxt = '0;
          case (in_kind) inside
            K_PUSH_FRONT, K_PUSH_BACK: begin
              out_valid_nxt = 1'b1;
              if (full) begin
                out_status_nxt = ST_FULL;
              end else begin
                out_status_nxt = ST_OK;
                count_nxt      = count_r + 1'b1;
              end
            end
            default: begin
              if (count_r == '0) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_EMPTY;
              end else if (in_kind == K_READ && !pos_ok) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_MISS;
              end else begin
                state_nxt = S_SCAN;
              end
            end
          endcase
        end
      end
      S_SCAN: begin
        if (kind_r == K_READ && PCW'(cnt_r) == PCW'(pos_r)) begin
          out_value_nxt = head32;
        end
        if (kind_r == K_FIND && scan_live && !found_r && chain[0] == key_r) begin
          found_nxt     = 1'b1;
          out_value_nxt = head32;
        end
        if (cnt_r == IW'(DEPTH - 1)) begin
          state_nxt      = S_IDLE;
          cnt_nxt        = '0;
          out_valid_nxt  = 1'b1;
          out_status_nxt = (kind_r == K_FIND && !found_nxt) ? ST_MISS : ST_OK;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      cnt_r       <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      cnt_r       <= cnt_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    pos_r        <= pos_nxt;
    key_r        <= key_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_read_value = out_value_r;

  a_no_result_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_valid_r && state_r == S_SCAN))
    else $error("Result pending during a scan.");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("Entry count above depth.");

  a_idle_cnt_zero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> cnt_r == '0)
    else $error("Scan counter not cleared while idle.");

  a_full_push_refused: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && full && (in_kind == K_PUSH_FRONT || in_kind == K_PUSH_BACK))
    |=> ($stable(count_r) && out_status_r == ST_FULL))
    else $error("Push to a full store changed the count.");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !full && (in_kind == K_PUSH_FRONT || in_kind == K_PUSH_BACK))
    |=> count_r == $past(count_r) + 1'b1)
    else $error("Accepted push did not grow the count.");

endmodule

### dv/deque_result_checker.sv
// Result checker for the deque store: watches both channels, keeps its own
// copy of the ring, front slot and entry count, and compares every result.
// Depends on dsis_pkg for the request kinds and status codes.
module deque_result_checker import dsis_pkg::*; #(
  parameter int DEPTH = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [1:0]         in_kind,
  input  logic signed [31:0] in_item_value,
  input  logic [9:0]         in_position,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [1:0]         out_status,
  input  logic signed [31:0] out_read_value,
  output int                 errors,
  output int                 open_count,
  output int                 compared
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] value;
  } answer_t;

  logic [31:0] ring [DEPTH];
  int unsigned head_slot;
  int unsigned fill;
  answer_t     answers_due[$];
  answer_t     want;
  answer_t     got;

  initial begin
    head_slot = 0;
    fill = 0;
    errors = 0;
    open_count = 0;
    compared = 0;
  end

  function automatic answer_t apply_request(logic [1:0] kind, logic [31:0] value,
                                            logic [9:0] pos);
    answer_t ans;
    int unsigned i;
    ans.status = ST_OK;
    ans.value = '0;
    if (kind == K_PUSH_FRONT || kind == K_PUSH_BACK) begin
      if (fill >= DEPTH) begin
        ans.status = ST_FULL;
      end else begin
        if (kind == K_PUSH_FRONT) begin
          head_slot = (head_slot + DEPTH - 1) % DEPTH;
          ring[head_slot] = value;
        end else begin
          ring[(head_slot + fill) % DEPTH] = value;
        end
        fill++;
      end
    end else if (fill == 0) begin
      ans.status = ST_EMPTY;
    end else if (kind == K_READ) begin
      if (pos < fill) begin
        ans.value = ring[(head_slot + pos) % DEPTH];
      end else begin
        ans.status = ST_MISS;
      end
    end else begin
      ans.status = ST_MISS;
      for (i = 0; i < fill; i++) begin
        if (ring[(head_slot + i) % DEPTH] == value) begin
          ans.status = ST_OK;
          ans.value = value;
          break;
        end
      end
    end
    return ans;
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got.status = out_status;
        got.value = out_read_value;
        if (answers_due.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("%0t: result with no transaction outstanding: status %0d value %h",
                     $realtime, got.status, got.value);
          end
        end else begin
          want = answers_due.pop_front();
          compared++;
          if (got.status !== want.status || got.value !== want.value) begin
            errors++;
            if (errors <= 10) begin
              $display("%0t: mismatch on result %0d: status exp %0d got %0d, value exp %h got %h",
                       $realtime, compared, want.status, got.status, want.value, got.value);
            end
          end
        end
      end
      if (in_valid && !in_stall) begin
        answers_due.push_back(apply_request(in_kind, in_item_value, in_position));
      end
    end
    open_count <= answers_due.size();
  end

endmodule

### dv/deque_store_with_index_and_search_top_tb.sv
// Testbench top for the deque store: clock, reset, request stimulus and
// result-side stalls, with the verdict taken from deque_result_checker.
// Depends on dsis_pkg, the deque store RTL and deque_result_checker.
module deque_store_with_index_and_search_top_tb import dsis_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 256;
  localparam int PHASE_ITEMS = 427;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         in_kind = K_PUSH_BACK;
  logic signed [31:0] in_item_value = '0;
  logic [9:0]         in_position = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         out_status;
  logic signed [31:0] out_read_value;

  int          chk_errors;
  int          chk_open;
  int          chk_compared;
  int          send_gap_pct = 10;
  int          recv_stall_pct = 56;
  int unsigned live = 0;
  int unsigned n_push = 0;
  int unsigned n_refused = 0;
  int unsigned n_read = 0;
  int unsigned n_find = 0;
  logic [31:0] pool[$];

  always #2 clk = ~clk;

  deque_store_with_index_and_search_top #(
    .DEPTH(DEPTH),
    .DATA_WIDTH(32)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_kind(in_kind),
    .in_item_value(in_item_value),
    .in_position(in_position),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_status(out_status),
    .out_read_value(out_read_value)
  );

  deque_result_checker #(
    .DEPTH(DEPTH)
  ) checker_i (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_kind(in_kind),
    .in_item_value(in_item_value),
    .in_position(in_position),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_status(out_status),
    .out_read_value(out_read_value),
    .errors(chk_errors),
    .open_count(chk_open),
    .compared(chk_compared)
  );

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  task automatic issue(input logic [1:0] kind, input logic [31:0] value,
                       input logic [9:0] pos);
    logic stalled;
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_item_value <= value;
    in_position <= pos;
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
    if (kind == K_PUSH_FRONT || kind == K_PUSH_BACK) begin
      n_push++;
      if (live < DEPTH) begin
        live++;
        pool.push_back(value);
      end else begin
        n_refused++;
      end
    end else if (kind == K_READ) begin
      n_read++;
    end else begin
      n_find++;
    end
  endtask

  task automatic random_request();
    int unsigned roll;
    int          near;
    logic [1:0]  kind;
    logic [31:0] value;
    logic [9:0]  pos;
    roll = $urandom_range(0, 99);
    value = $urandom;
    pos = 10'($urandom_range(0, 1023));
    if (roll < 35) begin
      kind = ($urandom_range(0, 1) == 0) ? K_PUSH_FRONT : K_PUSH_BACK;
      if ($urandom_range(0, 9) == 0 && pool.size() > 0) begin
        value = pool[$urandom_range(0, pool.size() - 1)];
      end
    end else if (roll < 68) begin
      kind = K_READ;
      roll = $urandom_range(0, 9);
      if (roll < 6 && live > 0) begin
        pos = 10'($urandom_range(0, live - 1));
      end else if (roll < 8) begin
        near = int'(live) + int'($urandom_range(0, 2)) - 1;
        if (near < 0) near = 0;
        if (near > 1023) near = 1023;
        pos = near[9:0];
      end
    end else begin
      kind = K_FIND;
      if ($urandom_range(0, 9) < 6 && pool.size() > 0) begin
        value = pool[$urandom_range(0, pool.size() - 1)];
      end
    end
    issue(kind, value, pos);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (chk_open != 0);
    @(posedge clk);
  endtask

  initial begin
    int n;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    issue(K_READ, 32'h0, 10'd0);
    issue(K_FIND, 32'h0, 10'd0);
    issue(K_READ, 32'h0, 10'd1023);
    issue(K_PUSH_BACK, 32'h7FFF_FFFF, 10'd1023);
    issue(K_PUSH_FRONT, 32'h8000_0000, 10'd0);
    issue(K_PUSH_BACK, 32'h0, 10'd0);
    issue(K_PUSH_FRONT, 32'hFFFF_FFFF, 10'd0);
    issue(K_READ, 32'h0, 10'd0);
    issue(K_READ, 32'h0, 10'd3);
    issue(K_READ, 32'h0, 10'd4);
    issue(K_READ, 32'hFFFF_FFFF, 10'd1023);
    issue(K_FIND, 32'h8000_0000, 10'd0);
    issue(K_FIND, 32'h0, 10'd0);
    issue(K_FIND, 32'h1234_5678, 10'd0);
    issue(K_PUSH_BACK, 32'h7FFF_FFFF, 10'd0);
    issue(K_FIND, 32'h7FFF_FFFF, 10'd0);
    issue(K_READ, 32'h0, 10'd1);
    issue(K_FIND, 32'hFFFF_FFFF, 10'd0);
    issue(K_PUSH_FRONT, 32'h5555_5555, 10'd0);
    issue(K_PUSH_BACK, 32'hAAAA_AAAA, 10'd0);
    issue(K_READ, 32'h0, 10'd6);
    issue(K_READ, 32'h0, 10'd7);

    for (n = 0; n < PHASE_ITEMS; n++) random_request();
    drain();
    send_gap_pct = 56;
    recv_stall_pct = 10;
    for (n = 0; n < PHASE_ITEMS; n++) random_request();
    drain();
    send_gap_pct = 0;
    recv_stall_pct = 0;
    for (n = 0; n < PHASE_ITEMS; n++) random_request();
    drain();
    repeat (DEPTH + 20) @(posedge clk);

    $display("Run covered %0d pushes (%0d refused at full), %0d reads and %0d finds.",
             n_push, n_refused, n_read, n_find);
    $display("Store reached %0d of %0d entries; %0d results compared over three idle profiles.",
             live, DEPTH, chk_compared);
    if (chk_errors == 0 && chk_open == 0) begin
      $display("PASS deque_store_with_index_and_search_top");
    end else begin
      $display("FAIL deque_store_with_index_and_search_top");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Timeout with %0d results outstanding.", chk_open);
    $display("FAIL deque_store_with_index_and_search_top");
    $finish;
  end

endmodule
